// ===== rtl/sgfw_pkg.sv =====
package sgfw_pkg;

    // Geometry defaults
    localparam int SCREEN_WIDTH_DEF  = 160;
    localparam int SCREEN_HEIGHT_DEF = 128;
    localparam int GLYPH_COUNT_DEF   = 256;
    localparam int MAX_SCALE_DEF     = 5;

    // Glyph cell: 6 column bytes, 8 rows
    localparam int GLYPH_COLS = 6;
    localparam int GLYPH_ROWS = 8;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_W = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_H = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FORE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BACK   = 3'd5;

    // Register reset values
    localparam logic [2:0]  SCALE_RST  = 3'd1;
    localparam logic [2:0]  FILL_RST   = 3'd1;
    localparam logic [7:0]  CLIP_W_RST = 8'd6;
    localparam logic [7:0]  CLIP_H_RST = 8'd8;
    localparam logic [15:0] FORE_RST   = 16'h0F00;
    localparam logic [15:0] BACK_RST   = 16'h0FFF;

    typedef enum logic [2:0] {
        OP_DRAW  = 3'd0,
        OP_PIXEL = 3'd1,
        OP_CLEAR = 3'd2,
        OP_LOAD  = 3'd3,
        OP_READ  = 3'd4
    } op_t;

endpackage

// ===== rtl/sgfw_ram.sv =====
module sgfw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/scaled_glyph_framebuffer_writer_top.sv =====
// Channel   Direction  Handshake          Payload
// -------   ---------  ---------          -------
// request   in         in_valid/in_stall  operation pos_x pos_y glyph_index font_column data_value
// result    out        out_valid/out_stall pixel_value in_screen (read pixel only)
// config    in         cfg_we             cfg_index cfg_data
//
// Load font writes the font store; write pixel uses the write stage, read pixel the result reg.
// Clear: one frame store write per cycle over all SCREEN_WIDTH*SCREEN_HEIGHT pixels.
// Draw: s x s pixels per glyph point, s the clamped scale: one pixel per cycle through the single
// frame store write port, one font store read per glyph column, and a trailing write from the write stage.
// rst_n clears control state and resets the config registers; both stores are not cleared.
// A read request also waits while the result register is still full; others do not.
module scaled_glyph_framebuffer_writer_top #(
    parameter int SCREEN_WIDTH  = sgfw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sgfw_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_COUNT   = sgfw_pkg::GLYPH_COUNT_DEF,
    parameter int MAX_SCALE     = sgfw_pkg::MAX_SCALE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       operation,
    input  logic [7:0]                       pos_x,
    input  logic [7:0]                       pos_y,
    input  logic [7:0]                       glyph_index,
    input  logic [2:0]                       font_column,
    input  logic [15:0]                      data_value,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [15:0]                      pixel_value,
    output logic                             in_screen,
    // config port
    input  logic                             cfg_we,
    input  logic [sgfw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sgfw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FRAME_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int FONT_DEPTH  = GLYPH_COUNT * sgfw_pkg::GLYPH_COLS;
    localparam int FONT_AW     = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
    // Scaled coordinates reach 255 + MAX_SCALE*8 - 1
    localparam int COORD_W     = $clog2(256 + MAX_SCALE * sgfw_pkg::GLYPH_ROWS);
    localparam int SCALE_W     = $clog2(MAX_SCALE + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FONT,
        ST_PIX,
        ST_READ
    } state_t;

    state_t state_reg;

    // config registers
    logic [2:0]  scale_reg;
    logic [2:0]  fill_reg;
    logic [7:0]  clip_w_reg;
    logic [7:0]  clip_h_reg;
    logic [15:0] fore_reg;
    logic [15:0] back_reg;

    // draw sequencer
    logic [7:0]         x_reg;
    logic [7:0]         y_reg;
    logic [7:0]         glyph_reg;
    logic [2:0]         col_reg;
    logic [2:0]         bit_reg;
    logic [SCALE_W-1:0] i_reg;
    logic [SCALE_W-1:0] j_reg;
    logic [SCALE_W-1:0] s_reg;
    logic [SCALE_W-1:0] f_reg;

    // clear sweep
    logic [FRAME_AW-1:0] clr_addr_reg;
    logic [15:0]         clr_data_reg;

    // pixel write stage
    logic               wr_valid_reg;
    logic [COORD_W-1:0] wr_x_reg;
    logic [COORD_W-1:0] wr_y_reg;
    logic [15:0]        wr_data_reg;

    // read pixel
    logic        rd_hit_reg;
    logic        out_valid_reg;
    logic [15:0] pixel_value_reg;
    logic        in_screen_reg;

    logic [SCALE_W-1:0] s_eff;
    logic [SCALE_W-1:0] f_eff;
    logic               accept;
    logic               in_pos_on;
    logic               glyph_ok;
    logic               wr_on;
    logic               last_j;
    logic               last_i;
    logic               last_bit;
    logic               clipped;
    logic               bit_set;
    logic [COORD_W-1:0] gen_x;
    logic [COORD_W-1:0] gen_y;
    logic [15:0]        gen_data;
    logic [2:0]         row;

    logic                frame_we;
    logic [FRAME_AW-1:0] frame_waddr;
    logic [15:0]         frame_wdata;
    logic                frame_re;
    logic [FRAME_AW-1:0] frame_raddr;
    logic [15:0]         frame_q;
    logic                font_we;
    logic [FONT_AW-1:0]  font_waddr;
    logic                font_re;
    logic [FONT_AW-1:0]  font_raddr;
    logic [7:0]          font_q;

    // clamp scale to 1..MAX_SCALE, fill to 1..scale
    always_comb
    begin
        if (scale_reg == 3'd0)
        begin
            s_eff = SCALE_W'(1);
        end
        else if (32'(scale_reg) > MAX_SCALE)
        begin
            s_eff = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            s_eff = SCALE_W'(scale_reg);
        end
        if (fill_reg == 3'd0)
        begin
            f_eff = SCALE_W'(1);
        end
        else if (32'(fill_reg) > 32'(s_eff))
        begin
            f_eff = s_eff;
        end
        else
        begin
            f_eff = SCALE_W'(fill_reg);
        end
    end

    assign in_pos_on = (32'(pos_x) < SCREEN_WIDTH) && (32'(pos_y) < SCREEN_HEIGHT);
    assign glyph_ok  = 32'(glyph_index) < GLYPH_COUNT;

    // Busy while sequencing or while a pixel write is in flight (read-after-write
    // interlock); a read also waits for the result register to empty.
    assign in_stall = (state_reg != ST_IDLE) || wr_valid_reg
                    || ((operation == sgfw_pkg::OP_READ) && out_valid_reg);
    assign accept   = in_valid && !in_stall;

    // point expansion: one pixel of the current point square per cycle
    assign row      = 3'(sgfw_pkg::GLYPH_ROWS - 1) - bit_reg;
    assign gen_x    = COORD_W'(32'(x_reg) + 32'(s_reg) * 32'(col_reg) + 32'(i_reg));
    assign gen_y    = COORD_W'(32'(y_reg) + 32'(s_reg) * 32'(row) + 32'(j_reg));
    assign clipped  = (32'(clip_w_reg) < 32'(col_reg) * 32'(s_reg))
                   || (32'(clip_h_reg) < 32'(bit_reg) * 32'(s_reg));
    assign bit_set  = font_q[bit_reg];
    assign gen_data = ((i_reg < f_reg) && (j_reg < f_reg)) ? (bit_set ? fore_reg : back_reg)
                                                            : 16'h0000;
    assign last_j   = j_reg == s_reg - SCALE_W'(1);
    assign last_i   = i_reg == s_reg - SCALE_W'(1);
    assign last_bit = bit_reg == 3'(sgfw_pkg::GLYPH_ROWS - 1);

    assign wr_on = wr_valid_reg && (32'(wr_x_reg) < SCREEN_WIDTH)
                && (32'(wr_y_reg) < SCREEN_HEIGHT);

    // store port control
    always_comb
    begin
        frame_we    = 1'b0;
        frame_waddr = FRAME_AW'(32'(wr_y_reg) * SCREEN_WIDTH + 32'(wr_x_reg));
        frame_wdata = wr_data_reg;
        if (state_reg == ST_CLEAR)
        begin
            frame_we    = 1'b1;
            frame_waddr = clr_addr_reg;
            frame_wdata = clr_data_reg;
        end
        else if (wr_on)
        begin
            frame_we = 1'b1;
        end
        frame_re    = accept && (operation == sgfw_pkg::OP_READ) && in_pos_on;
        frame_raddr = FRAME_AW'(32'(pos_y) * SCREEN_WIDTH + 32'(pos_x));
        font_we     = accept && (operation == sgfw_pkg::OP_LOAD) && glyph_ok
                   && (32'(font_column) < sgfw_pkg::GLYPH_COLS);
        font_waddr  = FONT_AW'(32'(glyph_index) * sgfw_pkg::GLYPH_COLS + 32'(font_column));
        font_re     = state_reg == ST_FONT;
        font_raddr  = FONT_AW'(32'(glyph_reg) * sgfw_pkg::GLYPH_COLS + 32'(col_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scale_reg       <= sgfw_pkg::SCALE_RST;
            fill_reg        <= sgfw_pkg::FILL_RST;
            clip_w_reg      <= sgfw_pkg::CLIP_W_RST;
            clip_h_reg      <= sgfw_pkg::CLIP_H_RST;
            fore_reg        <= sgfw_pkg::FORE_RST;
            back_reg        <= sgfw_pkg::BACK_RST;
            x_reg           <= '0;
            y_reg           <= '0;
            glyph_reg       <= '0;
            col_reg         <= '0;
            bit_reg         <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            s_reg           <= SCALE_W'(1);
            f_reg           <= SCALE_W'(1);
            clr_addr_reg    <= '0;
            clr_data_reg    <= '0;
            wr_valid_reg    <= 1'b0;
            wr_x_reg        <= '0;
            wr_y_reg        <= '0;
            wr_data_reg     <= '0;
            rd_hit_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            pixel_value_reg <= '0;
            in_screen_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sgfw_pkg::REG_SCALE:  scale_reg  <= cfg_data[2:0];
                    sgfw_pkg::REG_FILL:   fill_reg   <= cfg_data[2:0];
                    sgfw_pkg::REG_CLIP_W: clip_w_reg <= cfg_data[7:0];
                    sgfw_pkg::REG_CLIP_H: clip_h_reg <= cfg_data[7:0];
                    sgfw_pkg::REG_FORE:   fore_reg   <= cfg_data[15:0];
                    sgfw_pkg::REG_BACK:   back_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    wr_valid_reg <= accept && (operation == sgfw_pkg::OP_PIXEL);
                    if (accept)
                    begin
                        case (sgfw_pkg::op_t'(operation))
                            sgfw_pkg::OP_DRAW:
                            begin
                                if (glyph_ok)
                                begin
                                    x_reg     <= pos_x;
                                    y_reg     <= pos_y;
                                    glyph_reg <= glyph_index;
                                    col_reg   <= '0;
                                    bit_reg   <= '0;
                                    i_reg     <= '0;
                                    j_reg     <= '0;
                                    s_reg     <= s_eff;
                                    f_reg     <= f_eff;
                                    state_reg <= ST_FONT;
                                end
                            end
                            sgfw_pkg::OP_PIXEL:
                            begin
                                wr_x_reg     <= COORD_W'(pos_x);
                                wr_y_reg     <= COORD_W'(pos_y);
                                wr_data_reg  <= data_value;
                            end
                            sgfw_pkg::OP_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                clr_data_reg <= data_value;
                                state_reg    <= ST_CLEAR;
                            end
                            sgfw_pkg::OP_READ:
                            begin
                                rd_hit_reg <= in_pos_on;
                                state_reg  <= ST_READ;
                            end
                            default: ; // font load is done by the port control
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    wr_valid_reg <= 1'b0;
                    if (clr_addr_reg == FRAME_AW'(FRAME_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + FRAME_AW'(1);
                    end
                end
                ST_FONT:
                begin
                    // column byte arrives next cycle and holds for the whole column
                    wr_valid_reg <= 1'b0;
                    state_reg    <= ST_PIX;
                end
                ST_PIX:
                begin
                    wr_valid_reg <= !clipped;
                    wr_x_reg     <= gen_x;
                    wr_y_reg     <= gen_y;
                    wr_data_reg  <= gen_data;
                    if (!last_j)
                    begin
                        j_reg <= j_reg + SCALE_W'(1);
                    end
                    else
                    begin
                        j_reg <= '0;
                        if (!last_i)
                        begin
                            i_reg <= i_reg + SCALE_W'(1);
                        end
                        else
                        begin
                            i_reg <= '0;
                            if (!last_bit)
                            begin
                                bit_reg <= bit_reg + 3'd1;
                            end
                            else
                            begin
                                bit_reg <= '0;
                                if (col_reg == 3'(sgfw_pkg::GLYPH_COLS - 1))
                                begin
                                    state_reg <= ST_IDLE;
                                end
                                else
                                begin
                                    col_reg   <= col_reg + 3'd1;
                                    state_reg <= ST_FONT;
                                end
                            end
                        end
                    end
                end
                ST_READ:
                begin
                    // result register was empty when the read was taken
                    wr_valid_reg    <= 1'b0;
                    out_valid_reg   <= 1'b1;
                    pixel_value_reg <= rd_hit_reg ? frame_q : 16'h0000;
                    in_screen_reg   <= rd_hit_reg;
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    wr_valid_reg <= 1'b0;
                    state_reg    <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign in_screen   = in_screen_reg;

    sgfw_ram #(
        .WIDTH (16),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_we),
        .wr_addr (frame_waddr),
        .wr_data (frame_wdata),
        .rd_en   (frame_re),
        .rd_addr (frame_raddr),
        .rd_data (frame_q)
    );

    sgfw_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (font_we),
        .wr_addr (font_waddr),
        .wr_data (data_value[7:0]),
        .rd_en   (font_re),
        .rd_addr (font_raddr),
        .rd_data (font_q)
    );

endmodule

// ===== sim/scaled_glyph_framebuffer_writer_top_test.sv =====
`timescale 1ns / 1ps

module scaled_glyph_framebuffer_writer_top_test;

    localparam int SCR_W      = sgfw_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H      = sgfw_pkg::SCREEN_HEIGHT_DEF;
    localparam int GLYPH_N    = sgfw_pkg::GLYPH_COUNT_DEF;
    localparam int MAX_S      = sgfw_pkg::MAX_SCALE_DEF;
    localparam int GLYPH_COLS = sgfw_pkg::GLYPH_COLS;
    localparam int GLYPH_ROWS = sgfw_pkg::GLYPH_ROWS;

    // Operation codes the block must ignore
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // A full-screen clear is the longest legal quiet stretch;
    // the limit leaves a wide margin above it.
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 60;
    localparam int NUM_PHASES     = 8;
    localparam int NUM_DIRECTED   = 27;

    // One request on the input channel. When 'typed' is set the readback is
    // taken from the row itself instead of from the frame mirror.
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  glyph;
        logic [2:0]  col;
        logic [15:0] data;
        logic        typed;
        logic [15:0] want_pix;
        logic        want_on;
    } request_t;

    typedef struct packed {
        logic [15:0] pix;
        logic        on;
    } readback_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  glyph_index;
    logic [2:0]  font_column;
    logic [15:0] data_value;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] pixel_value;
    logic        in_screen;
    logic        cfg_we;
    logic [sgfw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sgfw_pkg::CFG_DATA_W-1:0]  cfg_data;

    scaled_glyph_framebuffer_writer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .glyph_index (glyph_index),
        .font_column (font_column),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_value (pixel_value),
        .in_screen   (in_screen),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Mirror of the block: frame store, font store and registers
    // ------------------------------------------------------------------
    logic [15:0] screen_copy [SCR_W*SCR_H];
    logic [7:0]  font_copy   [GLYPH_N*GLYPH_COLS];
    bit          font_valid  [GLYPH_N*GLYPH_COLS];
    int          ready_glyphs[$];     // glyphs with all six columns loaded

    logic [2:0]  scale_reg  = sgfw_pkg::SCALE_RST;
    logic [2:0]  fill_reg   = sgfw_pkg::FILL_RST;
    logic [7:0]  clip_w_reg = sgfw_pkg::CLIP_W_RST;
    logic [7:0]  clip_h_reg = sgfw_pkg::CLIP_H_RST;
    logic [15:0] fore_reg   = sgfw_pkg::FORE_RST;
    logic [15:0] back_reg   = sgfw_pkg::BACK_RST;

    readback_t   readback_q[$];       // reads accepted, result not yet seen

    // Run bookkeeping
    int mismatches;
    int useful_items;
    int accepted_count;
    int draws_done;
    int clears_done;
    int loads_done;
    int reads_checked;
    int input_stall_cycles;
    int quiet_cycles;
    int last_cost;
    int clears_left;
    int gap_pct;
    int stall_pct;
    int holds_asked;
    int holds_served;
    bit steady_tail;

    // ------------------------------------------------------------------
    // Directed rows: reset config, extremes, every operation and the
    // corner cases (off-screen write/read, bad font column, spare opcodes,
    // glyph clipped by the screen edge).
    // ------------------------------------------------------------------
    request_t directed_reqs [NUM_DIRECTED] = '{
        '{sgfw_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 3'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
        '{sgfw_pkg::OP_READ, 8'd159, 8'd127, 8'd0, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
        '{sgfw_pkg::OP_READ, 8'd160, 8'd0, 8'd0, 3'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd0, 8'd128, 8'd0, 3'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd255, 8'd255, 8'd0, 3'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_PIXEL, 8'd159, 8'd127, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd0, 3'd0, 16'h1234, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd159, 8'd127, 8'd0, 3'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
        // (255,0) would alias to (95,1) if the bounds check were missing
        '{sgfw_pkg::OP_READ, 8'd95, 8'd1, 8'd0, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd0, 16'hAB81, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd1, 16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd2, 16'hFF00, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd3, 16'h12A5, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd4, 16'h345A, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd5, 16'hFF01, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd6, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 3'd7, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{OP_SPARE5, 8'd1, 8'd1, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{OP_SPARE6, 8'd2, 8'd2, 8'hFF, 3'd7, 16'h5555, 1'b0, 16'h0000, 1'b0},
        '{OP_SPARE7, 8'd0, 8'd0, 8'd0, 3'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_DRAW, 8'd0, 8'd0, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd0, 8'd7, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd5, 8'd0, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_DRAW, 8'd156, 8'd122, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd159, 8'd127, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{sgfw_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int eff_scale();
        int s;
        s = scale_reg;
        if (s < 1) s = 1;
        if (s > MAX_S) s = MAX_S;
        return s;
    endfunction

    function automatic void plot(int px, int py, logic [15:0] c);
        if (px < SCR_W && py < SCR_H)
            screen_copy[py*SCR_W + px] = c;
    endfunction

    // Each glyph point becomes an s x s square; the top-left f x f corner
    // takes the point color, the rest goes to zero. Bit b is row 7-b.
    function automatic void paint_glyph(int x0, int y0, int g);
        int s, f, col, b, i, j;
        logic [7:0]  bits;
        logic [15:0] c;
        if (g >= GLYPH_N) return;
        s = eff_scale();
        f = fill_reg;
        if (f < 1) f = 1;
        if (f > s) f = s;
        for (col = 0; col < GLYPH_COLS; col++) begin
            bits = font_copy[g*GLYPH_COLS + col];
            for (b = 0; b < GLYPH_ROWS; b++) begin
                c = bits[b] ? fore_reg : back_reg;
                if (clip_w_reg < col*s || clip_h_reg < b*s) continue;
                for (i = 0; i < s; i++)
                    for (j = 0; j < s; j++)
                        plot(x0 + s*col + i, y0 + s*(GLYPH_ROWS-1-b) + j,
                             (i < f && j < f) ? c : 16'h0000);
            end
        end
    endfunction

    // cycles from one accepted request to the next
    function automatic int op_cost(logic [2:0] op);
        int s;
        s = eff_scale();
        case (op)
            sgfw_pkg::OP_CLEAR: return SCR_W*SCR_H + 1;
            sgfw_pkg::OP_DRAW:  return GLYPH_COLS*(1 + GLYPH_ROWS*s*s) + 2;
            sgfw_pkg::OP_PIXEL: return 2;
            sgfw_pkg::OP_READ:  return 2;
            default:            return 1;
        endcase
    endfunction

    // Called at the edge that accepts a request: update the mirror in
    // request order and queue the readback for reads.
    function automatic void apply_command(request_t r);
        int k, n, base;
        bit full;
        readback_t rb;
        accepted_count++;
        last_cost = op_cost(r.op);
        case (r.op)
            sgfw_pkg::OP_DRAW: begin
                paint_glyph(r.x, r.y, r.glyph);
                draws_done++;
                useful_items++;
            end
            sgfw_pkg::OP_PIXEL: begin
                plot(r.x, r.y, r.data);
                useful_items++;
            end
            sgfw_pkg::OP_CLEAR: begin
                for (k = 0; k < SCR_W*SCR_H; k++) screen_copy[k] = r.data;
                clears_done++;
                useful_items++;
            end
            sgfw_pkg::OP_LOAD: begin
                if (r.col < GLYPH_COLS && r.glyph < GLYPH_N) begin
                    base = r.glyph*GLYPH_COLS;
                    font_copy[base + r.col] = r.data[7:0];
                    font_valid[base + r.col] = 1'b1;
                    loads_done++;
                    useful_items++;
                    full = 1'b1;
                    for (k = 0; k < GLYPH_COLS; k++) full &= font_valid[base + k];
                    if (full) begin
                        for (n = 0; n < ready_glyphs.size(); n++)
                            if (ready_glyphs[n] == r.glyph) full = 1'b0;
                        if (full) ready_glyphs.push_back(r.glyph);
                    end
                end
            end
            sgfw_pkg::OP_READ: begin
                useful_items++;
                if (r.typed) begin
                    rb.pix = r.want_pix;
                    rb.on  = r.want_on;
                end else if (r.x < SCR_W && r.y < SCR_H) begin
                    rb.pix = screen_copy[r.y*SCR_W + r.x];
                    rb.on  = 1'b1;
                end else begin
                    rb.pix = 16'h0000;
                    rb.on  = 1'b0;
                end
                readback_q.push_back(rb);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Enter right after a rising edge. in_valid is only lowered for a gap,
    // so back-to-back requests keep it high without a glitch.
    task automatic issue(input request_t r);
        int gap;
        if (!steady_tail && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= r.op;
        pos_x       <= r.x;
        pos_y       <= r.y;
        glyph_index <= r.glyph;
        font_column <= r.col;
        data_value  <= r.data;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        apply_command(r);
    endtask

    function automatic request_t noise_request();
        request_t r;
        r.op       = sgfw_pkg::OP_READ;
        r.x        = 8'($urandom);
        r.y        = 8'($urandom);
        r.glyph    = 8'($urandom);
        r.col      = 3'($urandom);
        r.data     = 16'($urandom);
        r.typed    = 1'b0;
        r.want_pix = 16'h0000;
        r.want_on  = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] pick_x();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, SCR_W-1));
    endfunction

    function automatic logic [7:0] pick_y();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, SCR_H-1));
    endfunction

    // One random action; glyph loads come as a full six-column sequence
    // so that later draws only touch loaded font entries.
    task automatic random_action();
        request_t r, probe;
        int roll, k, g, first, reps, s;
        roll = $urandom_range(0, 99);
        r = noise_request();
        if (roll < 14 || ready_glyphs.size() == 0) begin
            g = $urandom_range(0, GLYPH_N-1);
            first = $urandom_range(0, GLYPH_COLS-1);
            for (k = 0; k < GLYPH_COLS; k++) begin
                r = noise_request();
                r.op    = sgfw_pkg::OP_LOAD;
                r.glyph = 8'(g);
                r.col   = 3'((first + k) % GLYPH_COLS);
                issue(r);
            end
        end else if (roll < 44) begin
            r.op    = sgfw_pkg::OP_DRAW;
            r.glyph = 8'(ready_glyphs[$urandom_range(0, ready_glyphs.size()-1)]);
            r.x     = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 150));
            r.y     = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 120));
            issue(r);
            // probe the freshly drawn cell, up to one pixel past its right and bottom edges
            s = eff_scale();
            reps = $urandom_range(1, 3);
            for (k = 0; k < reps; k++) begin
                probe    = noise_request();
                probe.x  = 8'(r.x + $urandom_range(0, GLYPH_COLS*s));
                probe.y  = 8'(r.y + $urandom_range(0, GLYPH_ROWS*s));
                issue(probe);
            end
        end else if (roll < 56) begin
            r.op = sgfw_pkg::OP_PIXEL;
            r.x  = pick_x();
            r.y  = pick_y();
            issue(r);
            if ($urandom_range(0, 1) == 1) begin
                probe   = noise_request();
                probe.x = r.x;
                probe.y = r.y;
                issue(probe);
            end
        end else if (roll < 80) begin
            r.x = pick_x();
            r.y = pick_y();
            issue(r);
        end else if (roll < 86) begin
            r.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
            issue(r);
        end else if (roll < 92) begin
            r.op  = sgfw_pkg::OP_LOAD;
            r.col = 3'($urandom_range(GLYPH_COLS, 7));
            issue(r);
        end else if (roll < 94 && clears_left > 0) begin
            clears_left--;
            r.op = sgfw_pkg::OP_CLEAR;
            issue(r);
        end else begin
            issue(r);
        end
    endtask

    task automatic random_action_read();
        request_t r;
        r = noise_request();
        r.x = 8'($urandom_range(0, SCR_W-1));
        r.y = 8'($urandom_range(0, SCR_H-1));
        issue(r);
    endtask

    task automatic run_random(input int n);
        int start;
        start = useful_items;
        while (useful_items - start < n) random_action();
    endtask

    // Fence read: once its result is back every earlier request is done.
    task automatic settle();
        request_t r;
        r = noise_request();
        r.x = 8'($urandom_range(0, SCR_W-1));
        r.y = 8'($urandom_range(0, SCR_H-1));
        issue(r);
        in_valid <= 1'b0;
        while (readback_q.size() != 0) @(posedge clk);
        repeat (last_cost + 8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register writes; cfg_we stays high across a burst of writes
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [sgfw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sgfw_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            sgfw_pkg::REG_SCALE:  scale_reg  = val[2:0];
            sgfw_pkg::REG_FILL:   fill_reg   = val[2:0];
            sgfw_pkg::REG_CLIP_W: clip_w_reg = val[7:0];
            sgfw_pkg::REG_CLIP_H: clip_h_reg = val[7:0];
            sgfw_pkg::REG_FORE:   fore_reg   = val;
            sgfw_pkg::REG_BACK:   back_reg   = val;
            default: ;
        endcase
    endtask

    // Upper bits of the narrow registers carry noise; only the low bits count.
    task automatic program_regs(input logic [2:0] sc, input logic [2:0] fl,
                                input logic [7:0] cw, input logic [7:0] ch,
                                input logic [15:0] fg, input logic [15:0] bg);
        write_reg(sgfw_pkg::REG_SCALE,  {13'($urandom), sc});
        write_reg(sgfw_pkg::REG_FILL,   {13'($urandom), fl});
        write_reg(sgfw_pkg::REG_CLIP_W, {8'($urandom), cw});
        write_reg(sgfw_pkg::REG_CLIP_H, {8'($urandom), ch});
        write_reg(sgfw_pkg::REG_FORE,   fg);
        write_reg(sgfw_pkg::REG_BACK,   bg);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!steady_tail && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        // keep the log bounded if the block is badly broken
        if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    always @(posedge clk) begin : result_check
        readback_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (readback_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel_value=%h in_screen=%b",
                                          pixel_value, in_screen));
            end else begin
                want = readback_q.pop_front();
                reads_checked++;
                if (pixel_value !== want.pix)
                    report_mismatch($sformatf("pixel_value got %h want %h",
                                              pixel_value, want.pix));
                if (in_screen !== want.on)
                    report_mismatch($sformatf("in_screen got %b want %b",
                                              in_screen, want.on));
            end
        end
    end

    // Watchdog: counts edges at which neither channel moves a request/result.
    always @(posedge clk) begin : watchdog
        if (in_valid === 1'b1 && in_stall === 1'b1) input_stall_cycles++;
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles, %0d reads outstanding",
                         quiet_cycles, readback_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int k, p;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= sgfw_pkg::OP_READ;
        pos_x       <= 8'd0;
        pos_y       <= 8'd0;
        glyph_index <= 8'd0;
        font_column <= 3'd0;
        data_value  <= 16'h0000;
        cfg_we      <= 1'b0;
        cfg_index   <= sgfw_pkg::REG_SCALE;
        cfg_data    <= 16'h0000;
        clears_left = 4;
        gap_pct     = 20;
        stall_pct   = 20;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run on the reset register values
        for (k = 0; k < NUM_DIRECTED; k++) issue(directed_reqs[k]);
        run_random(40);
        settle();

        for (p = 1; p < NUM_PHASES; p++) begin
            case (p)
                // scale and fill of zero clamp to one; widest clip; color extremes
                1: program_regs(3'd0, 3'd0, 8'd255, 8'd255, 16'hFFFF, 16'h0000);
                // scale above the max clamps to it, fill follows
                2: program_regs(3'd7, 3'd7, 8'd255, 8'd255, 16'($urandom), 16'($urandom));
                // zero clip keeps only the bottom-left point
                3: program_regs(3'd2, 3'd1, 8'd0, 8'd0, 16'($urandom), 16'($urandom));
                // fill above scale clamps to scale
                4: program_regs(3'd3, 3'd5, 8'($urandom_range(0, 20)),
                                8'($urandom_range(0, 30)), 16'($urandom), 16'($urandom));
                default: program_regs(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                      ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(0, 30)),
                                      ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(0, 40)),
                                      16'($urandom), 16'($urandom));
            endcase
            // phase 1 runs without any idling; others pick a random density
            gap_pct   = (p == 1) ? 0 : 20 * $urandom_range(0, 2);
            stall_pct = (p == 1) ? 0 : 20 * $urandom_range(0, 2);
            if (p == NUM_PHASES-1) steady_tail = 1'b1;

            if (p == 4) begin
                // long result hold-off while reads keep coming: the result
                // register fills and the input side has to stall
                holds_asked++;
                for (k = 0; k < 8; k++) random_action_read();
            end
            run_random(60);
            settle();
        end

        repeat (last_cost + 16) @(posedge clk);

        $display("Ran %0d requests: %0d draws, %0d clears, %0d font loads, %0d reads checked",
                 accepted_count, draws_done, clears_done, loads_done, reads_checked);
        $display("%0d register settings incl. clamp cases; input held off for %0d cycles",
                 NUM_PHASES, input_stall_cycles);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
